// ===== hw/rtl/dud_pkg.sv =====
// Shared types, constants and character tables for the data URL decoder.
// No dependencies; every module of the decoder imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dud_pkg;

    // Most results one character can cause: three bytes and the status.
    localparam int DUD_MAX_RES     = 4;
    localparam int DUD_RES_CNT_W   = 3;
    localparam int DUD_QUEUE_DEPTH = 4;

    // Characters with a special meaning.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LOWER_B = 8'h62;

    // Length of "data:" and "base64".
    localparam logic [2:0] PREFIX_LEN  = 3'd5;
    localparam logic [2:0] KEYWORD_LEN = 3'd6;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_META   = 2'd1,
        PH_DATA   = 2'd2,
        PH_REJECT = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_DATA = 2'd1,
        ST_BAD_B64  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] in_char;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       is_final;
        t_status    status;
    } t_out_item;

    // All results caused by one input transaction, first result in slot zero.
    typedef struct packed {
        t_out_item [DUD_MAX_RES-1:0] res;
        logic [DUD_RES_CNT_W-1:0]    count;
    } t_bundle;

    // Character of "data:" at a given position.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h64;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h61;
            3'd4:    ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Character of "base64" at a given position.
    function automatic logic [7:0] keyword_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h73;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h36;
            3'd5:    ch = 8'h34;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Hex digit value; bit 4 is set when the character is a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    // Base64 alphabet value; bit 6 is set when the character is in the alphabet.
    function automatic logic [6:0] sextet_value(input logic [7:0] c);
        logic [6:0] v;
        v = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = {1'b1, 6'(c - 8'h47)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 6'(c + 8'h04)};
        end else if (c == CH_PLUS) begin
            v = {1'b1, 6'd62};
        end else if (c == CH_SLASH) begin
            v = {1'b1, 6'd63};
        end
        return v;
    endfunction

    // White space for base64: space, tab, LF, VT, FF, CR.
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Plain character in percent mode: a plus sign stands for a space.
    function automatic logic [7:0] plain_map(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    function automatic t_out_item make_byte(input logic [7:0] b);
        t_out_item r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.is_final   = 1'b0;
        r.status     = ST_OK;
        return r;
    endfunction

    function automatic t_out_item make_final(input t_status st);
        t_out_item r;
        r.out_byte   = 8'h00;
        r.byte_valid = 1'b0;
        r.is_final   = 1'b1;
        r.status     = st;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dud_front.sv =====
// Front end of the data URL decoder: accepts characters, tracks the URL state
// and builds the bundle of results for each transaction. Depends on dud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dud_front
    import dud_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_in_item  i_item,
    input  wire       i_valid,
    output logic      o_ready,
    input  wire       i_q_ready,
    output logic      o_push,
    output t_bundle   o_bundle
);

    // URL state.
    t_phase             r_phase, n_phase;
    logic [2:0]         r_prefix_matched, n_prefix_matched;
    logic [2:0]         r_keyword_matched, n_keyword_matched;
    logic               r_base64_mode, n_base64_mode;
    logic [11:0]        r_bit_acc, n_bit_acc;
    logic signed [3:0]  r_bit_count, n_bit_count;
    logic [15:0]        r_held_chars, n_held_chars;
    logic [1:0]         r_held_count, n_held_count;
    logic               r_any_output, n_any_output;

    logic               w_accept;
    logic [DUD_RES_CNT_W-1:0] w_cnt;
    t_out_item [DUD_MAX_RES-1:0] w_res;

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid && i_q_ready;

    // Next state and results for the character on the input.
    always_comb begin
        logic [7:0]        c;
        logic [7:0]        second;
        logic [4:0]        hi;
        logic [4:0]        lo;
        logic [6:0]        sx;
        logic [11:0]       acc;
        logic [11:0]       shifted;
        logic signed [3:0] bc;
        t_status           st;

        n_phase           = r_phase;
        n_prefix_matched  = r_prefix_matched;
        n_keyword_matched = r_keyword_matched;
        n_base64_mode     = r_base64_mode;
        n_bit_acc         = r_bit_acc;
        n_bit_count       = r_bit_count;
        n_held_chars      = r_held_chars;
        n_held_count      = r_held_count;
        n_any_output      = r_any_output;
        w_cnt             = '0;
        w_res             = '0;

        c       = i_item.in_char;
        second  = r_held_chars[15:8];
        hi      = hex_value(second);
        lo      = hex_value(c);
        sx      = sextet_value(c);
        acc     = {r_bit_acc[5:0], sx[5:0]};
        bc      = r_bit_count + 4'sd6;
        shifted = acc >> bc[2:0];
        st      = ST_NOT_DATA;

        case (r_phase)
            PH_PREFIX: begin
                if (c == prefix_char(r_prefix_matched)) begin
                    n_prefix_matched = r_prefix_matched + 3'd1;
                    if (n_prefix_matched == PREFIX_LEN) begin
                        n_phase = PH_META;
                    end
                end else begin
                    n_phase = PH_REJECT;
                end
            end
            PH_META: begin
                if (c == CH_COMMA) begin
                    n_phase = PH_DATA;
                end else if (!r_base64_mode) begin
                    if (c == keyword_char(r_keyword_matched)) begin
                        n_keyword_matched = r_keyword_matched + 3'd1;
                    end else begin
                        n_keyword_matched = (c == CH_LOWER_B) ? 3'd1 : 3'd0;
                    end
                    if (n_keyword_matched == KEYWORD_LEN) begin
                        n_base64_mode = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                if (r_base64_mode) begin
                    // Base64: padding and white space are skipped.
                    if (c != CH_EQUAL && !is_space(c)) begin
                        if (!sx[6]) begin
                            n_phase = PH_REJECT;
                        end else begin
                            n_bit_acc   = acc;
                            n_bit_count = bc;
                            if (!bc[3]) begin
                                w_res[w_cnt[1:0]] = make_byte(shifted[7:0]);
                                w_cnt             = w_cnt + 3'd1;
                                n_any_output      = 1'b1;
                                n_bit_count       = bc - 4'sd8;
                            end
                        end
                    end
                end else if (r_held_count == 2'd0) begin
                    // No escape pending.
                    if (c == CH_PERCENT) begin
                        n_held_chars = {8'h00, c};
                        n_held_count = 2'd1;
                    end else begin
                        w_res[w_cnt[1:0]] = make_byte(plain_map(c));
                        w_cnt             = w_cnt + 3'd1;
                        n_any_output      = 1'b1;
                    end
                end else if (r_held_count == 2'd1) begin
                    n_held_chars = {c, r_held_chars[7:0]};
                    n_held_count = 2'd2;
                end else begin
                    // Third character of a possible escape.
                    n_held_chars = 16'h0000;
                    n_held_count = 2'd0;
                    n_any_output = 1'b1;
                    if (hi[4]) begin
                        if (lo[4]) begin
                            w_res[w_cnt[1:0]] = make_byte({hi[3:0], lo[3:0]});
                        end else begin
                            w_res[w_cnt[1:0]] = make_byte({4'h0, hi[3:0]});
                        end
                        w_cnt = w_cnt + 3'd1;
                    end else begin
                        w_res[w_cnt[1:0]] = make_byte(CH_PERCENT);
                        w_cnt             = w_cnt + 3'd1;
                        if (second == CH_PERCENT) begin
                            n_held_chars = {c, CH_PERCENT};
                            n_held_count = 2'd2;
                        end else begin
                            w_res[w_cnt[1:0]] = make_byte(plain_map(second));
                            w_cnt             = w_cnt + 3'd1;
                            if (c == CH_PERCENT) begin
                                n_held_chars = {8'h00, c};
                                n_held_count = 2'd1;
                            end else begin
                                w_res[w_cnt[1:0]] = make_byte(plain_map(c));
                                w_cnt             = w_cnt + 3'd1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // Last character: flush held characters, close with a status, start over.
        if (i_item.is_last) begin
            if (n_phase == PH_DATA && !n_base64_mode) begin
                if (n_held_count != 2'd0) begin
                    w_res[w_cnt[1:0]] = make_byte(CH_PERCENT);
                    w_cnt             = w_cnt + 3'd1;
                    n_any_output      = 1'b1;
                end
                if (n_held_count == 2'd2) begin
                    w_res[w_cnt[1:0]] = make_byte(plain_map(n_held_chars[15:8]));
                    w_cnt             = w_cnt + 3'd1;
                end
            end
            if (n_phase == PH_DATA) begin
                st = n_any_output ? ST_OK : ST_EMPTY;
            end else if (n_phase == PH_REJECT && n_base64_mode) begin
                st = ST_BAD_B64;
            end
            w_res[w_cnt[1:0]] = make_final(st);
            w_cnt             = w_cnt + 3'd1;

            n_phase           = PH_PREFIX;
            n_prefix_matched  = 3'd0;
            n_keyword_matched = 3'd0;
            n_base64_mode     = 1'b0;
            n_bit_acc         = 12'h000;
            n_bit_count       = -4'sd8;
            n_held_chars      = 16'h0000;
            n_held_count      = 2'd0;
            n_any_output      = 1'b0;
        end
    end

    // Only transactions that cause results enter the queue.
    assign o_push          = w_accept && (w_cnt != '0);
    assign o_bundle.res    = w_res;
    assign o_bundle.count  = w_cnt;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_PREFIX;
            r_prefix_matched  <= 3'd0;
            r_keyword_matched <= 3'd0;
            r_base64_mode     <= 1'b0;
            r_bit_acc         <= 12'h000;
            r_bit_count       <= -4'sd8;
            r_held_chars      <= 16'h0000;
            r_held_count      <= 2'd0;
            r_any_output      <= 1'b0;
        end else if (w_accept) begin
            r_phase           <= n_phase;
            r_prefix_matched  <= n_prefix_matched;
            r_keyword_matched <= n_keyword_matched;
            r_base64_mode     <= n_base64_mode;
            r_bit_acc         <= n_bit_acc;
            r_bit_count       <= n_bit_count;
            r_held_chars      <= n_held_chars;
            r_held_count      <= n_held_count;
            r_any_output      <= n_any_output;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dud_queue.sv =====
// Short queue of result bundles between the front and back ends of the
// data URL decoder. Depends on dud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dud_queue
    import dud_pkg::*;
#(
    parameter int DEPTH = DUD_QUEUE_DEPTH
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_push,
    input  t_bundle  i_bundle,
    output logic     o_full,
    output logic     o_empty,
    input  wire      i_pop,
    output t_bundle  o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_bundle          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dud_back.sv =====
// Back end of the data URL decoder: takes the bundle at the queue head apart
// and sends its results one per transaction through an output register.
// Depends on dud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dud_back
    import dud_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_bundle    i_head,
    input  wire        i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  wire        i_ready,
    output t_out_item  o_item
);

    logic                     r_valid;
    t_out_item                r_item;
    logic [1:0]               r_idx;
    logic                     w_load;
    logic                     w_last_slot;
    logic [DUD_RES_CNT_W-1:0] w_next_idx;

    // The output register takes a new result whenever it is empty or drained.
    assign w_load      = !i_empty && (!r_valid || i_ready);
    assign w_next_idx  = {1'b0, r_idx} + 3'd1;
    assign w_last_slot = (w_next_idx == i_head.count);
    assign o_pop       = w_load && w_last_slot;
    assign o_valid     = r_valid;
    assign o_item      = r_item;

    // Slot index within the head bundle and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last_slot ? 2'd0 : w_next_idx[1:0];
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_head.res[r_idx];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/data_url_decoder_unit.sv =====
// Top level of the streaming data URL decoder.
// Instantiates dud_front, dud_queue and dud_back; depends on dud_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The decoder takes a data URL one character per input transaction and
// returns decoded bytes followed by one closing status transaction on the
// character flagged is_last. A character is accepted in the cycle it is
// offered as long as the result queue (QUEUE_DEPTH bundles) has room.
// Results leave through a registered output at one per cycle while the
// receiver is ready; a character causes 0 to 4 results. The first result
// of a character is written into the queue when the character is accepted
// and then loaded into the output register before it is offered.
// Input and output stall independently of each other through the queue.

module data_url_decoder_unit
    import dud_pkg::*;
#(
    parameter int QUEUE_DEPTH = DUD_QUEUE_DEPTH  // 2 or more
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out_item  o_out_item
);

    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    t_bundle w_bundle;
    t_bundle w_head;

    // Character classification and state tracking.
    dud_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_in_item),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_q_ready (!w_full),
        .o_push    (w_push),
        .o_bundle  (w_bundle)
    );

    // Result bundles waiting for the output.
    dud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_bundle),
        .o_full   (w_full),
        .o_empty  (w_empty),
        .i_pop    (w_pop),
        .o_head   (w_head)
    );

    // Serialization of results.
    dud_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    // The front end never writes into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("bundle pushed into a full queue");

    // A pushed bundle holds between one and four results.
    a_bundle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_bundle.count != '0 && w_bundle.count <= 3'd4))
        else $error("bundle with an impossible result count");

    // The last character of a URL always yields a closing result.
    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.is_last) |-> w_push)
        else $error("last character produced no results");

    // The back end only pops a bundle that is there.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for data_url_decoder_unit, the streaming data URL decoder.
// Depends on dud_pkg for the item types and character codes. A built-in predictor
// produces the expected output transactions, which are compared in order.
`timescale 1ns / 1ps

module tb_top;
    import dud_pkg::*;

    typedef logic [7:0] t_chars[$];

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_CHARS = 50;
    localparam int REPORT_LIMIT = 10;

    localparam logic [39:0] DATA_TAG = "data:";
    localparam logic [47:0] B64_TAG  = "base64";

    string b64_set  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    string hex_set  = "0123456789abcdefABCDEFg";
    string meta_set = "bas64e;b";

    // Block inputs start at known values.
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Idle controls shared by the sender and the receiver.
    int unsigned in_idle_pct  = 0;
    int unsigned out_idle_pct = 0;
    int unsigned hold_req     = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;
    int unsigned cycle_cnt    = 0;
    int          fail_count   = 0;

    // Decoded output transactions still to arrive, oldest first.
    t_out_item decoded_q[$];

    // Decoder state tracked by the predictor.
    t_phase            st_phase;
    logic [2:0]        st_pre;
    logic [2:0]        st_kw;
    logic              st_b64;
    logic [11:0]       st_acc;
    logic signed [3:0] st_bits;
    logic [15:0]       st_held;
    logic [1:0]        st_held_n;
    logic              st_any;

    data_url_decoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_decoder();
        st_phase  = PH_PREFIX;
        st_pre    = '0;
        st_kw     = '0;
        st_b64    = 1'b0;
        st_acc    = '0;
        st_bits   = -4'sd8;
        st_held   = '0;
        st_held_n = '0;
        st_any    = 1'b0;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic int sextet(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return c - "A";
        if (c >= "a" && c <= "z") return c - "a" + 26;
        if (c >= "0" && c <= "9") return c - "0" + 52;
        if (c == CH_PLUS) return 62;
        if (c == CH_SLASH) return 63;
        return -1;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] unplus(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        t_out_item r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.is_final   = 1'b0;
        r.status     = ST_OK;
        decoded_q = {decoded_q, r};
        st_any = 1'b1;
    endfunction

    function automatic void push_status(input t_status s);
        t_out_item r;
        r.out_byte   = 8'h00;
        r.byte_valid = 1'b0;
        r.is_final   = 1'b1;
        r.status     = s;
        decoded_q = {decoded_q, r};
    endfunction

    // A percent sign is held back until its two following characters are known.
    function automatic void start_plain(input logic [7:0] c);
        if (c == CH_PERCENT) begin
            st_held   = {8'h00, c};
            st_held_n = 2'd1;
        end else begin
            push_byte(unplus(c));
        end
    endfunction

    function automatic void percent_step(input logic [7:0] c);
        logic [7:0] sec;
        int hi;
        int lo;
        if (st_held_n == 2'd0) begin
            start_plain(c);
        end else if (st_held_n == 2'd1) begin
            st_held[15:8] = c;
            st_held_n     = 2'd2;
        end else begin
            sec       = st_held[15:8];
            st_held   = '0;
            st_held_n = 2'd0;
            hi        = hex_digit(sec);
            if (hi >= 0) begin
                // One hex digit is enough; a non-hex second digit is dropped.
                lo = hex_digit(c);
                if (lo >= 0) begin
                    push_byte({hi[3:0], lo[3:0]});
                end else begin
                    push_byte({4'h0, hi[3:0]});
                end
            end else begin
                push_byte(CH_PERCENT);
                if (sec == CH_PERCENT) begin
                    st_held   = {c, CH_PERCENT};
                    st_held_n = 2'd2;
                end else begin
                    push_byte(unplus(sec));
                    start_plain(c);
                end
            end
        end
    endfunction

    function automatic void b64_step(input logic [7:0] c);
        int d;
        logic [11:0] sh;
        if (c == CH_EQUAL || is_blank(c)) return;
        d = sextet(c);
        if (d < 0) begin
            st_phase = PH_REJECT;
            return;
        end
        st_acc  = {st_acc[5:0], d[5:0]};
        st_bits = st_bits + 4'sd6;
        if (st_bits >= 0) begin
            sh = st_acc >> st_bits[2:0];
            push_byte(sh[7:0]);
            st_bits = st_bits - 4'sd8;
        end
    endfunction

    // Expected output transactions for one accepted input transaction.
    function automatic void decode_char(input t_in_item it);
        logic [7:0] c;
        t_status st;
        c = it.in_char;
        case (st_phase)
            PH_PREFIX: begin
                if (st_pre < PREFIX_LEN && c == DATA_TAG[8*(4-st_pre) +: 8]) begin
                    st_pre = st_pre + 3'd1;
                    if (st_pre == PREFIX_LEN) st_phase = PH_META;
                end else begin
                    st_phase = PH_REJECT;
                end
            end
            PH_META: begin
                if (c == CH_COMMA) begin
                    st_phase = PH_DATA;
                end else if (!st_b64) begin
                    if (st_kw < KEYWORD_LEN && c == B64_TAG[8*(5-st_kw) +: 8]) begin
                        st_kw = st_kw + 3'd1;
                    end else begin
                        st_kw = (c == CH_LOWER_B) ? 3'd1 : 3'd0;
                    end
                    if (st_kw == KEYWORD_LEN) st_b64 = 1'b1;
                end
            end
            PH_DATA: begin
                if (st_b64) begin
                    b64_step(c);
                end else begin
                    percent_step(c);
                end
            end
            default: begin
            end
        endcase

        // Closing transaction: flush held escape characters, then the status.
        if (it.is_last) begin
            if (st_phase == PH_DATA && !st_b64) begin
                if (st_held_n >= 2'd1) push_byte(CH_PERCENT);
                if (st_held_n >= 2'd2) push_byte(unplus(st_held[15:8]));
            end
            if (st_phase == PH_DATA) begin
                st = st_any ? ST_OK : ST_EMPTY;
            end else if (st_phase == PH_REJECT && st_b64) begin
                st = ST_BAD_B64;
            end else begin
                st = ST_NOT_DATA;
            end
            push_status(st);
            clear_decoder();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        if ($urandom_range(9) == 0) return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    function automatic int unsigned pick_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 25;
            default: return 60;
        endcase
    endfunction

    function automatic void add_text(ref t_chars u, input string s);
        for (int i = 0; i < s.len(); i++) u = {u, s[i]};
    endfunction

    // Offer one character and wait for its transaction. Valid stays high
    // afterwards so that the next character can follow without a gap.
    task automatic send_char(input logic [7:0] c, input logic last);
        int unsigned gap;
        t_in_item it;
        gap = ($urandom_range(99) < in_idle_pct) ? gap_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.in_char = c;
        it.is_last = last;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decode_char(it);
    endtask

    task automatic send_url(input t_chars u);
        foreach (u[i]) send_char(u[i], i == u.size() - 1);
    endtask

    task automatic send_text(input string s);
        t_chars u;
        add_text(u, s);
        send_url(u);
    endtask

    // Drop valid for a cycle so that no character is offered twice.
    task automatic in_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] blank_char();
        if ($urandom_range(5) == 0) return CH_SPACE;
        return 8'($urandom_range(13, 9));
    endfunction

    // Mostly well-formed URLs with random content; the rest is noise and
    // URLs with a broken prefix or without a comma.
    function automatic t_chars random_url();
        t_chars u;
        int unsigned kind;
        int unsigned len;
        int unsigned r;
        int unsigned cut;
        logic b64;
        kind = $urandom_range(99);
        if (kind < 8) begin
            len = $urandom_range(8, 1);
            repeat (len) u = {u, 8'($urandom)};
            return u;
        end
        if (kind < 16) begin
            cut = $urandom_range(4);
            for (int i = 0; i < cut; i++) u = {u, DATA_TAG[8*(4-i) +: 8]};
            u = {u, 8'($urandom)};
            len = $urandom_range(5);
            repeat (len) u = {u, 8'($urandom)};
            return u;
        end
        add_text(u, "data:");
        b64 = ($urandom_range(1) == 1);
        case ($urandom_range(3))
            0: if (b64) add_text(u, ";base64");
            1: begin
                add_text(u, "text/plain");
                if (b64) add_text(u, ";charset=x;base64");
            end
            2: begin
                if (b64) begin
                    add_text(u, "bbase64");
                end else begin
                    add_text(u, "bas64e");
                end
            end
            default: begin
                len = $urandom_range(6);
                repeat (len) u = {u, meta_set[$urandom_range(meta_set.len() - 1)]};
            end
        endcase
        if ($urandom_range(24) == 0) return u;
        u = {u, CH_COMMA};
        len = $urandom_range(14);
        repeat (len) begin
            r = $urandom_range(99);
            if (b64) begin
                if (r < 80) begin
                    u = {u, b64_set[$urandom_range(b64_set.len() - 1)]};
                end else if (r < 88) begin
                    u = {u, CH_EQUAL};
                end else if (r < 95) begin
                    u = {u, blank_char()};
                end else begin
                    u = {u, 8'($urandom)};
                end
            end else begin
                if (r < 40) begin
                    u = {u, 8'($urandom)};
                end else if (r < 60) begin
                    u = {u, CH_PERCENT};
                end else if (r < 85) begin
                    u = {u, hex_set[$urandom_range(hex_set.len() - 1)]};
                end else begin
                    u = {u, CH_PLUS};
                end
            end
        end
        return u;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Wrong or cut prefix, missing comma and an empty data part.
    task automatic test_prefix_check();
        in_idle_pct  = 25;
        out_idle_pct = 25;
        send_text("x");
        send_text("Data:,a");
        send_text("data");
        send_text("data:text");
        send_text("data:,");
        in_idle();
    endtask

    // Escapes with one and two digits, broken escapes, plus signs, byte extremes
    // and escapes cut by the end of the URL.
    task automatic test_percent_escapes();
        t_chars u;
        in_idle_pct  = 0;
        out_idle_pct = 0;
        send_text("data:,%41%4a%4G%zz");
        send_text("data:,a+b%%41");
        add_text(u, "data:,");
        u = {u, 8'h00};
        u = {u, 8'hFF};
        add_text(u, "%00%FF%ff");
        send_url(u);
        send_text("data:,%z%");
        send_text("data:,%4");
        send_text("data:,%+");
        in_idle();
    endtask

    // Base64 data with padding, white space, errors and the keyword in odd places.
    task automatic test_base64_data();
        t_chars u;
        in_idle_pct  = 25;
        out_idle_pct = 60;
        send_text("data:;base64,QUJD");
        add_text(u, "data:text/plain;base64,QQ==");
        for (int c = 9; c <= 13; c++) u = {u, 8'(c)};
        u = {u, CH_SPACE};
        send_url(u);
        send_text("data:bbase64,/+90");
        send_text("data:;base64,QU!D");
        send_text("data:;base64,!");
        send_text("data:;base64,==");
        send_text("data:;bas64,QQ");
        send_text("data:base64,AAAA////");
        in_idle();
    endtask

    // The receiver holds off for a long stretch while characters keep coming.
    task automatic test_output_stall();
        t_chars u;
        in_idle_pct  = 0;
        out_idle_pct = 0;
        hold_req     = 250;
        add_text(u, "data:,");
        repeat (40) u = {u, 8'($urandom_range(8'h7A, 8'h61))};
        send_url(u);
        u = {};
        add_text(u, "data:;base64,");
        repeat (24) u = {u, b64_set[$urandom_range(b64_set.len() - 1)]};
        send_url(u);
        in_idle();
    endtask

    task automatic test_random_urls();
        t_chars u;
        int unsigned sent;
        sent = 0;
        while (sent < RANDOM_CHARS) begin
            // New idle mix every few URLs, including stretches with none.
            if ($urandom_range(3) == 0) begin
                in_idle_pct  = pick_pct();
                out_idle_pct = pick_pct();
            end
            u = random_url();
            send_url(u);
            sent += u.size();
        end
        in_idle();
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Ready with random stalls; a requested hold-off is counted here.
    always @(posedge i_clk) begin : rx_ready
        logic rdy;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rdy = 1'b0;
        end else if (hold_req > 0) begin
            hold_left = hold_req - 1;
            hold_req  = 0;
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
            if ($urandom_range(99) < out_idle_pct) stall_left = gap_len();
        end
        i_out_ready <= rdy;
    end

    // Compare every output transaction with the oldest expected one.
    always @(posedge i_clk) begin : out_check
        t_out_item want;
        logic bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decoded_q.size() == 0) begin
                if (fail_count < REPORT_LIMIT) begin
                    $display("%0t: unexpected result byte %02h valid %0b final %0b status %0d",
                             $realtime, o_out_item.out_byte, o_out_item.byte_valid,
                             o_out_item.is_final, o_out_item.status);
                end
                fail_count++;
            end else begin
                want = decoded_q[0];
                decoded_q.delete(0);
                bad  = (o_out_item.out_byte !== want.out_byte)
                    || (o_out_item.byte_valid !== want.byte_valid)
                    || (o_out_item.is_final !== want.is_final)
                    || (o_out_item.status !== want.status);
                if (bad) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $display("%0t: mismatch got byte %02h valid %0b final %0b status %0d",
                                 $realtime, o_out_item.out_byte, o_out_item.byte_valid,
                                 o_out_item.is_final, o_out_item.status);
                        $display("%0t:        want byte %02h valid %0b final %0b status %0d",
                                 $realtime, want.out_byte, want.byte_valid,
                                 want.is_final, want.status);
                    end
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, decoded_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        clear_decoder();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_prefix_check();
        test_percent_escapes();
        test_base64_data();
        test_output_stall();
        test_random_urls();

        // Let the remaining results drain, then watch for stray ones.
        out_idle_pct = 0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/dud_pkg.sv
hw/rtl/dud_front.sv
hw/rtl/dud_queue.sv
hw/rtl/dud_back.sv
hw/rtl/data_url_decoder_unit.sv
tb/sv/tb_top.sv
